// ----- hdl/spq_pkg.sv -----
// Shared constants and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int TAG_BITS_DEF      = 8;

    localparam int OCC_BITS    = 5;
    localparam int STATUS_BITS = 2;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// Sorted priority queue: circular entry memory walked by a small sequencer.
//
// Usage:
//   s_axis carries one command item: tuser = mode (insert or extract),
//   tdata = new_tag then new_priority. m_axis returns one result item per
//   command: tuser = status, tdata = new_head, out_tag, out_priority,
//   occupancy. Entries are kept head first in descending priority; equal
//   priorities leave in arrival order.
// Timing:
//   A refused insert or an extract from an empty queue is answered in the
//   cycle after acceptance. An extract does one registered memory read of
//   the head. An insert walks back from the tail, reading each entry moved
//   and then comparing and writing it on the single memory port.
//   One command is in flight at a time; s_axis_tready is low while it runs.
// Reset: aresetn low empties the queue and drops any pending result.
// Stall: a finished result holds in the output register until taken; a new
//   command is taken in the same cycle the result leaves.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
    localparam int IN_W   = TAG_BITS + PRIORITY_BITS,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 1 + TAG_BITS + PRIORITY_BITS + spq_pkg::OCC_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [IN_TW-1:0]                 s_axis_tdata,  // new_tag, new_priority
    input  wire logic                             s_axis_tuser,  // mode
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // new_head, out_tag, out_priority, occupancy
    output      logic [OUT_TW-1:0]                m_axis_tdata,
    output      logic [spq_pkg::STATUS_BITS-1:0]  m_axis_tuser   // status
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC = spq_pkg::OCC_BITS;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [TAG_BITS-1:0]      tag;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CMP,
        ST_EXT
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic   mem_we;
    entry_t mem_wdata;
    logic [AW-1:0] mem_addr;

    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [TAG_BITS-1:0]      new_tag_reg, new_tag_next;
    logic [PRIORITY_BITS-1:0] new_prio_reg, new_prio_next;

    logic                            m_valid_reg, m_valid_next;
    logic [spq_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic                            hc_reg, hc_next;
    logic [TAG_BITS-1:0]             otag_reg, otag_next;
    logic [PRIORITY_BITS-1:0]        oprio_reg, oprio_next;
    logic [OCC-1:0]                  occ_reg, occ_next;

    logic          s_accept;
    logic [AW-1:0] k;
    logic [AW:0]   addr_sum;
    logic [CW-1:0] count_inc, count_dec;
    logic [CW+OCC-1:0] occ_inc_w, occ_dec_w, occ_cur_w;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign count_inc = CW'(count_reg + 1'b1);
    assign count_dec = CW'(count_reg - 1'b1);
    assign occ_inc_w = {{OCC{1'b0}}, count_inc};
    assign occ_dec_w = {{OCC{1'b0}}, count_dec};
    assign occ_cur_w = {{OCC{1'b0}}, count_reg};

    // logical position k maps onto the circular buffer starting at head
    always_comb begin
        addr_sum = {1'b0, head_reg} + {1'b0, k};
        if (addr_sum >= DEPTH_A) begin
            addr_sum = addr_sum - DEPTH_A;
        end
        mem_addr = addr_sum[AW-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        j_next        = j_reg;
        new_tag_next  = new_tag_reg;
        new_prio_next = new_prio_reg;
        m_valid_next  = m_valid_reg;
        status_next   = status_reg;
        hc_next       = hc_reg;
        otag_next     = otag_reg;
        oprio_next    = oprio_reg;
        occ_next      = occ_reg;
        mem_we        = 1'b0;
        mem_wdata     = '{prio: new_prio_reg, tag: new_tag_reg};
        k             = j_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                k = '0;
                if (s_accept) begin
                    new_tag_next  = s_axis_tdata[TAG_BITS-1:0];
                    new_prio_next = s_axis_tdata[IN_W-1:TAG_BITS];
                    if (s_axis_tuser == spq_pkg::MODE_INSERT) begin
                        if (count_reg == DEPTH_C) begin
                            m_valid_next = 1'b1;
                            status_next  = spq_pkg::STATUS_FULL;
                            hc_next      = 1'b0;
                            otag_next    = '0;
                            oprio_next   = '0;
                            occ_next     = occ_cur_w[OCC-1:0];
                        end else begin
                            j_next     = count_reg[AW-1:0];
                            state_next = ST_WALK;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            m_valid_next = 1'b1;
                            status_next  = spq_pkg::STATUS_EMPTY;
                            hc_next      = 1'b0;
                            otag_next    = '0;
                            oprio_next   = '0;
                            occ_next     = '0;
                        end else begin
                            // head read is issued this cycle
                            state_next = ST_EXT;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (j_reg == '0) begin
                    // walked past every entry: new one becomes the head
                    k            = '0;
                    mem_we       = 1'b1;
                    count_next   = count_inc;
                    m_valid_next = 1'b1;
                    status_next  = spq_pkg::STATUS_DONE;
                    hc_next      = 1'b1;
                    otag_next    = '0;
                    oprio_next   = '0;
                    occ_next     = occ_inc_w[OCC-1:0];
                    state_next   = ST_IDLE;
                end else begin
                    k          = AW'(j_reg - 1'b1);
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                k      = j_reg;
                mem_we = 1'b1;
                if (rd_data_reg.prio >= new_prio_reg) begin
                    count_next   = count_inc;
                    m_valid_next = 1'b1;
                    status_next  = spq_pkg::STATUS_DONE;
                    hc_next      = 1'b0;
                    otag_next    = '0;
                    oprio_next   = '0;
                    occ_next     = occ_inc_w[OCC-1:0];
                    state_next   = ST_IDLE;
                end else begin
                    // move the lower entry back one slot and keep walking
                    mem_wdata  = rd_data_reg;
                    j_next     = AW'(j_reg - 1'b1);
                    state_next = ST_WALK;
                end
            end
            ST_EXT: begin
                k            = '0;
                count_next   = count_dec;
                head_next    = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(head_reg + 1'b1);
                m_valid_next = 1'b1;
                status_next  = spq_pkg::STATUS_DONE;
                hc_next      = 1'b0;
                otag_next    = rd_data_reg.tag;
                oprio_next   = rd_data_reg.prio;
                occ_next     = occ_dec_w[OCC-1:0];
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg        <= j_next;
        new_tag_reg  <= new_tag_next;
        new_prio_reg <= new_prio_next;
        status_reg   <= status_next;
        hc_reg       <= hc_next;
        otag_reg     <= otag_next;
        oprio_reg    <= oprio_next;
        occ_reg      <= occ_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = OUT_TW'({occ_reg, oprio_reg, otag_reg, hc_reg});

endmodule

`default_nettype wire

// ----- hdl/spq_checker.sv -----
// Port-level assertions for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
    localparam int OUT_W  = 1 + TAG_BITS + PRIORITY_BITS + spq_pkg::OCC_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [OUT_TW-1:0]                m_axis_tdata,
    input wire logic [spq_pkg::STATUS_BITS-1:0]  m_axis_tuser
);

    localparam int OCC_LO = 1 + TAG_BITS + PRIORITY_BITS;

    logic                            hc;
    logic [TAG_BITS+PRIORITY_BITS-1:0] payload;
    logic [spq_pkg::OCC_BITS-1:0]    occ;

    assign hc      = m_axis_tdata[0];
    assign payload = m_axis_tdata[OCC_LO-1:1];
    assign occ     = m_axis_tdata[OUT_W-1:OCC_LO];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no new command while a result sits unread
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("command taken while result stalled");

    // refused items report zero payload and no head change
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_FULL ||
                          m_axis_tuser == spq_pkg::STATUS_EMPTY)
        |-> !hc && payload == '0)
        else $error("refused item carries payload");

    // empty-queue extract reports zero occupancy
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_EMPTY) |-> occ == '0)
        else $error("empty extract with nonzero occupancy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS),
    .TAG_BITS     (TAG_BITS)
) u_spq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
